// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared types and constants of the double-ended queue with cursor.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int KIND_W  = 4;
    localparam int VALUE_W = 32;
    localparam int FILL_W  = 5;
    localparam int WIDE_W  = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK    = 4'd0,
        KIND_PUSH_FRONT   = 4'd1,
        KIND_POP          = 4'd2,
        KIND_READ_FRONT   = 4'd3,
        KIND_READ_BACK    = 4'd4,
        KIND_CURSOR_BEGIN = 4'd5,
        KIND_CURSOR_NEXT  = 4'd6,
        KIND_CURSOR_READ  = 4'd7,
        KIND_CURSOR_WRITE = 4'd8
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] in_value;
    } t_op;

    typedef struct packed {
        logic               ok;
        logic [VALUE_W-1:0] out_value;
        logic               is_empty;
        logic [FILL_W-1:0]  fill_count;
        logic               cursor_valid;
    } t_res;

endpackage

// ===== rtl/dq_chan_if.sv =====
// ----------------------------------------------------------------------------
// Deque channel interface
// Valid/ready channel carrying one payload beat of type T.
// ----------------------------------------------------------------------------
interface dq_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/deque_with_cursor.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue with cursor
// Bounded deque in a ring of DEPTH slots held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   i_op carries one operation per beat (kind, in_value): push back, push
//   front, pop, read front, read back, and cursor begin, next, read, write.
//   o_res returns exactly one result beat per operation: ok, out_value,
//   is_empty, fill_count and cursor_valid as they stand after the operation.
//   Operations that only move pointers or write a slot load the result
//   register at the accepting edge; the next operation may be accepted in
//   the following cycle unless that result beat is stalled. Reads (front,
//   back, cursor) register the slot data at the accepting edge, then load
//   the result register from ST_READ, in which no operation is accepted.
//   The result register sits between the two channels. While a result beat
//   is stalled, i_op.ready is low unless o_res.ready is high in that cycle.
//   Reset clears the head pointer, fill count and cursor and empties the
//   result register; slot contents are not cleared, since only stored
//   elements are ever read.
// ----------------------------------------------------------------------------
module deque_with_cursor #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dq_chan_if.sink      i_op,
    dq_chan_if.source    o_res
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [ELEM_WIDTH-1:0] mem [DEPTH];

    dq_pkg::t_state r_state, n_state;
    logic [IW-1:0]  r_head, n_head;
    logic [CW-1:0]  r_count, n_count;
    logic [IW-1:0]  r_off, n_off;
    logic           r_live, n_live;

    logic                  r_out_valid, n_out_valid;
    logic                  r_out_ok;
    logic                  r_out_rd;
    logic                  r_out_empty;
    logic [dq_pkg::FILL_W-1:0] r_out_fill;
    logic                  r_out_cv;
    logic [ELEM_WIDTH-1:0] r_rd_data;

    logic           accept;
    logic           out_beat;
    logic           ok;
    logic           wr_en;
    logic           rd_en;
    logic           use_head_dec;
    logic           cur;
    logic           full;
    logic           empty;
    logic           live_final;
    logic [CW-1:0]  pos_off;
    logic [CW:0]    pos_sum;
    logic [IW-1:0]  ring_addr;
    logic [IW-1:0]  head_dec;
    logic [IW-1:0]  mem_addr;
    logic [dq_pkg::WIDE_W-1:0] wr_wide;
    logic [dq_pkg::WIDE_W-1:0] rd_wide;
    logic [31:0]    fill_wide;

    assign out_beat    = r_out_valid && o_res.ready;
    assign i_op.ready  = (r_state == dq_pkg::ST_IDLE) && (!r_out_valid || o_res.ready);
    assign accept      = i_op.valid && i_op.ready;

    assign cur   = r_live && ({{(CW-IW){1'b0}}, r_off} < r_count);
    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // Single ring adder; the operand is chosen by the operation.
    assign pos_sum   = {1'b0, {(CW-IW){1'b0}}, r_head} + {1'b0, pos_off};
    assign ring_addr = (pos_sum >= (CW+1)'(DEPTH)) ? IW'(pos_sum - (CW+1)'(DEPTH))
                                                   : IW'(pos_sum);
    assign head_dec  = (r_head == '0) ? IW'(DEPTH - 1) : r_head - 1'b1;
    assign mem_addr  = use_head_dec ? head_dec : ring_addr;

    assign wr_wide = dq_pkg::WIDE_W'(i_op.data.in_value);

    always_comb begin
        ok           = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        use_head_dec = 1'b0;
        pos_off      = '0;
        n_head       = r_head;
        n_count      = r_count;
        n_off        = r_off;
        n_live       = r_live;
        case (dq_pkg::t_kind'(i_op.data.kind))
            dq_pkg::KIND_PUSH_BACK: begin
                pos_off = r_count;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                    ok      = 1'b1;
                end
            end
            dq_pkg::KIND_PUSH_FRONT: begin
                use_head_dec = 1'b1;
                if (!full) begin
                    wr_en   = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    if (cur) begin
                        n_off = r_off + 1'b1;
                    end
                    ok = 1'b1;
                end
            end
            dq_pkg::KIND_POP: begin
                pos_off = CW'(1);
                if (!empty) begin
                    n_head  = ring_addr;
                    n_count = r_count - 1'b1;
                    if (cur) begin
                        if (r_off == '0) begin
                            n_live = 1'b0;
                        end else begin
                            n_off = r_off - 1'b1;
                        end
                    end
                    ok = 1'b1;
                end
            end
            dq_pkg::KIND_READ_FRONT: begin
                if (!empty) begin
                    rd_en = 1'b1;
                    ok    = 1'b1;
                end
            end
            dq_pkg::KIND_READ_BACK: begin
                pos_off = r_count - 1'b1;
                if (!empty) begin
                    rd_en = 1'b1;
                    ok    = 1'b1;
                end
            end
            dq_pkg::KIND_CURSOR_BEGIN: begin
                n_off  = '0;
                n_live = !empty;
                ok     = !empty;
            end
            dq_pkg::KIND_CURSOR_NEXT: begin
                if (cur && (({{(CW-IW){1'b0}}, r_off} + 1'b1) < r_count)) begin
                    n_off = r_off + 1'b1;
                    ok    = 1'b1;
                end else begin
                    n_live = 1'b0;
                end
            end
            dq_pkg::KIND_CURSOR_READ: begin
                pos_off = {{(CW-IW){1'b0}}, r_off};
                if (cur) begin
                    rd_en = 1'b1;
                    ok    = 1'b1;
                end
            end
            dq_pkg::KIND_CURSOR_WRITE: begin
                pos_off = {{(CW-IW){1'b0}}, r_off};
                if (cur) begin
                    wr_en = 1'b1;
                    ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign live_final = n_live && ({{(CW-IW){1'b0}}, n_off} < n_count);
    assign fill_wide  = 32'(n_count);

    // Read results are held back in ST_READ until the slot data is registered.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (out_beat) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            dq_pkg::ST_IDLE: begin
                if (accept) begin
                    if (rd_en) begin
                        n_state = dq_pkg::ST_READ;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            dq_pkg::ST_READ: begin
                n_state     = dq_pkg::ST_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dq_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_live      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
                r_off   <= n_off;
                r_live  <= live_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_ok    <= ok;
            r_out_rd    <= rd_en;
            r_out_empty <= (n_count == '0);
            r_out_fill  <= fill_wide[dq_pkg::FILL_W-1:0];
            r_out_cv    <= live_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[mem_addr] <= wr_wide[ELEM_WIDTH-1:0];
        end
        if (accept && rd_en) begin
            r_rd_data <= mem[mem_addr];
        end
    end

    assign rd_wide = dq_pkg::WIDE_W'(r_rd_data);

    assign o_res.valid             = r_out_valid;
    assign o_res.data.ok           = r_out_ok;
    assign o_res.data.out_value    = r_out_rd ? rd_wide[dq_pkg::VALUE_W-1:0] : '0;
    assign o_res.data.is_empty     = r_out_empty;
    assign o_res.data.fill_count   = r_out_fill;
    assign o_res.data.cursor_valid = r_out_cv;

endmodule

// ===== rtl/dq_checker.sv =====
// ----------------------------------------------------------------------------
// Deque result checker
// Port-level checks on the result channel of the deque, bound to the top.
// ----------------------------------------------------------------------------
module dq_checker #(
    parameter int DEPTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic                          i_res_ok,
    input logic [dq_pkg::VALUE_W-1:0]    i_res_value,
    input logic                          i_res_empty,
    input logic [dq_pkg::FILL_W-1:0]     i_res_fill,
    input logic                          i_res_cv
);

    // A stalled result beat keeps its valid, ok flag, value, fill count and cursor flag.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_ok)
            && $stable(i_res_value) && $stable(i_res_fill) && $stable(i_res_cv))
        else $error("result beat changed while stalled");

    // A failed operation never returns data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ok |-> i_res_value == '0)
        else $error("failed operation returned nonzero data");

    // The empty flag agrees with the fill count while the count cannot wrap.
    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (DEPTH < 32) |-> i_res_empty == (i_res_fill == '0))
        else $error("empty flag disagrees with fill count");

    // A live cursor needs at least one stored element.
    a_cursor_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_cv |-> !i_res_empty)
        else $error("cursor valid on an empty queue");

endmodule

bind deque_with_cursor dq_checker #(
    .DEPTH(DEPTH)
) u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_ok    (o_res.data.ok),
    .i_res_value (o_res.data.out_value),
    .i_res_empty (o_res.data.is_empty),
    .i_res_fill  (o_res.data.fill_count),
    .i_res_cv    (o_res.data.cursor_valid)
);

// ===== tb/tb_deque_with_cursor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deque with cursor testbench
// Drives operation beats with random gaps and result stalls. A shadow copy of
// the deque predicts each result beat, and results are checked in order.
// ----------------------------------------------------------------------------
module tb_deque_with_cursor;

    localparam int          DQ_DEPTH       = 16;
    localparam int          DQ_IW          = $clog2(DQ_DEPTH);
    localparam int          RANDOM_OPS     = 1000;
    localparam int          CALM_TAIL      = 150;
    localparam int          HOLD_AT_OP     = 400;
    localparam int          HOLD_CYCLES    = 80;
    localparam int          CYCLE_LIMIT    = 200_000;
    localparam logic [3:0]  KIND_UNUSED_LO = 4'd9;
    localparam logic [3:0]  KIND_UNUSED_HI = 4'd15;

    // Shadow deque: predicts one result beat per operation and holds the
    // predictions until the block returns them.
    class deque_tracker;
        logic [dq_pkg::VALUE_W-1:0] slot_mem [DQ_DEPTH];
        int unsigned        head;
        int unsigned        fill;
        int unsigned        cur_off;
        bit                 cur_live;
        dq_pkg::t_res       pending [$];
        int                 fails;

        function new();
            head     = 0;
            fill     = 0;
            cur_off  = 0;
            cur_live = 1'b0;
            fails    = 0;
        endfunction

        function void apply_op(dq_pkg::t_op op);
            dq_pkg::t_res r;
            bit   live_now;
            r = '0;
            live_now = cur_live && (cur_off < fill);
            case (op.kind)
                dq_pkg::KIND_PUSH_BACK: begin
                    if (fill < DQ_DEPTH) begin
                        slot_mem[DQ_IW'((head + fill) % DQ_DEPTH)] = op.in_value;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_PUSH_FRONT: begin
                    if (fill < DQ_DEPTH) begin
                        head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
                        slot_mem[DQ_IW'(head)] = op.in_value;
                        fill++;
                        if (live_now) cur_off++;
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_POP: begin
                    if (fill > 0) begin
                        head = (head + 1) % DQ_DEPTH;
                        fill--;
                        if (live_now) begin
                            if (cur_off == 0) cur_live = 1'b0;
                            else cur_off--;
                        end
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_READ_FRONT: begin
                    if (fill > 0) begin
                        r.out_value = slot_mem[DQ_IW'(head)];
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_READ_BACK: begin
                    if (fill > 0) begin
                        r.out_value = slot_mem[DQ_IW'((head + fill - 1) % DQ_DEPTH)];
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_CURSOR_BEGIN: begin
                    cur_off  = 0;
                    cur_live = (fill > 0);
                    r.ok     = cur_live;
                end
                dq_pkg::KIND_CURSOR_NEXT: begin
                    if (live_now && cur_off + 1 < fill) begin
                        cur_off++;
                        r.ok = 1'b1;
                    end else begin
                        cur_live = 1'b0;
                    end
                end
                dq_pkg::KIND_CURSOR_READ: begin
                    if (live_now) begin
                        r.out_value = slot_mem[DQ_IW'((head + cur_off) % DQ_DEPTH)];
                        r.ok = 1'b1;
                    end
                end
                dq_pkg::KIND_CURSOR_WRITE: begin
                    if (live_now) begin
                        slot_mem[DQ_IW'((head + cur_off) % DQ_DEPTH)] = op.in_value;
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!(cur_live && cur_off < fill)) cur_live = 1'b0;
            r.is_empty     = (fill == 0);
            r.fill_count   = fill[dq_pkg::FILL_W-1:0];
            r.cursor_valid = cur_live;
            pending.push_back(r);
        endfunction

        function void match_result(dq_pkg::t_res got);
            dq_pkg::t_res want;
            if (pending.size() == 0) begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result beat: ok=%0d val=%08h empty=%0d ",
                             got.ok, got.out_value, got.is_empty,
                             "fill=%0d cur=%0d", got.fill_count, got.cursor_valid);
                return;
            end
            want = pending.pop_front();
            if (got.ok !== want.ok || got.out_value !== want.out_value ||
                got.is_empty !== want.is_empty || got.fill_count !== want.fill_count ||
                got.cursor_valid !== want.cursor_valid) begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: exp ok=%0d val=%08h empty=%0d fill=%0d cur=%0d",
                             want.ok, want.out_value, want.is_empty, want.fill_count,
                             want.cursor_valid,
                             " | got ok=%0d val=%08h empty=%0d fill=%0d cur=%0d",
                             got.ok, got.out_value, got.is_empty,
                             got.fill_count, got.cursor_valid);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dq_chan_if #(.T(dq_pkg::t_op))  op_ch ();
    dq_chan_if #(.T(dq_pkg::t_res)) res_ch ();

    deque_with_cursor #(
        .DEPTH      (DQ_DEPTH),
        .ELEM_WIDTH (dq_pkg::VALUE_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op_ch),
        .o_res   (res_ch)
    );

    deque_tracker tracker = new();
    int           ops_taken = 0;
    int           cycles    = 0;
    bit           calm      = 1'b0;
    bit           held_once = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (op_ch.valid && op_ch.ready) begin
                tracker.apply_op(op_ch.data);
                ops_taken++;
            end
            if (res_ch.valid && res_ch.ready) tracker.match_result(res_ch.data);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off mid-run so the
    // block backs up onto its input, and no stalls near the end.
    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held_once && ops_taken >= HOLD_AT_OP) begin
                held_once = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!calm && ((ops_taken / 100) % 3 != 0) &&
                         $urandom_range(0, 5) == 0) begin
                res_ch.ready <= 1'b0;
                n = $urandom_range(1, 9);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_op(input logic [dq_pkg::KIND_W-1:0]  kind,
                           input logic [dq_pkg::VALUE_W-1:0] val);
        dq_pkg::t_op op;
        op.kind     = kind;
        op.in_value = val;
        @(negedge i_clk);
        op_ch.valid <= 1'b1;
        op_ch.data  <= op;
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    task automatic drop_valid(input int n);
        @(negedge i_clk);
        op_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    function automatic logic [dq_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // Operation mix shifts with the phase: filling, draining, and an even mix
    // in the two remaining phases.
    function automatic logic [dq_pkg::KIND_W-1:0] pick_kind(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (r < 35) return dq_pkg::KIND_PUSH_BACK;
                if (r < 60) return dq_pkg::KIND_PUSH_FRONT;
                if (r < 68) return dq_pkg::KIND_POP;
            end
            1: begin
                if (r < 12) return dq_pkg::KIND_PUSH_BACK;
                if (r < 22) return dq_pkg::KIND_PUSH_FRONT;
                if (r < 60) return dq_pkg::KIND_POP;
            end
            default: begin
                if (r < 20) return dq_pkg::KIND_PUSH_BACK;
                if (r < 35) return dq_pkg::KIND_PUSH_FRONT;
                if (r < 55) return dq_pkg::KIND_POP;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < 15) return dq_pkg::KIND_READ_FRONT;
        if (r < 30) return dq_pkg::KIND_READ_BACK;
        if (r < 42) return dq_pkg::KIND_CURSOR_BEGIN;
        if (r < 60) return dq_pkg::KIND_CURSOR_NEXT;
        if (r < 75) return dq_pkg::KIND_CURSOR_READ;
        if (r < 90) return dq_pkg::KIND_CURSOR_WRITE;
        return dq_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    endfunction

    function automatic logic [dq_pkg::KIND_W-1:0] pick_walk_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return dq_pkg::KIND_CURSOR_NEXT;
        if (r < 60) return dq_pkg::KIND_CURSOR_READ;
        if (r < 80) return dq_pkg::KIND_CURSOR_WRITE;
        if (r < 90) return dq_pkg::KIND_PUSH_FRONT;
        return dq_pkg::KIND_POP;
    endfunction

    initial begin
        int                        real_ops;
        int                        steps;
        logic [dq_pkg::KIND_W-1:0] kind;
        i_rst_n       = 1'b0;
        op_ch.valid   = 1'b0;
        op_ch.data    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty deque and invalid cursor.
        send_op(dq_pkg::KIND_POP, '0);
        send_op(dq_pkg::KIND_READ_FRONT, '0);
        send_op(dq_pkg::KIND_READ_BACK, '0);
        send_op(dq_pkg::KIND_CURSOR_BEGIN, '0);
        send_op(dq_pkg::KIND_CURSOR_NEXT, '0);
        send_op(dq_pkg::KIND_CURSOR_READ, '0);
        send_op(dq_pkg::KIND_CURSOR_WRITE, 32'h1234_5678);
        send_op(KIND_UNUSED_HI, '1);
        // Both ends, extremes of the value.
        send_op(dq_pkg::KIND_PUSH_BACK, '1);
        send_op(dq_pkg::KIND_PUSH_FRONT, '0);
        send_op(dq_pkg::KIND_PUSH_BACK, 32'hA5A5_5A5A);
        send_op(dq_pkg::KIND_READ_FRONT, '0);
        send_op(dq_pkg::KIND_READ_BACK, '0);
        // Cursor walk; a front push must keep it on the same element.
        send_op(dq_pkg::KIND_CURSOR_BEGIN, '0);
        send_op(dq_pkg::KIND_CURSOR_NEXT, '0);
        send_op(dq_pkg::KIND_PUSH_FRONT, 32'h8765_4321);
        send_op(dq_pkg::KIND_CURSOR_READ, '0);
        send_op(dq_pkg::KIND_CURSOR_WRITE, 32'h0000_0001);
        send_op(dq_pkg::KIND_CURSOR_READ, '0);
        send_op(dq_pkg::KIND_CURSOR_NEXT, '0);
        send_op(dq_pkg::KIND_CURSOR_NEXT, '0);
        // Popping the cursor's element invalidates it.
        send_op(dq_pkg::KIND_CURSOR_BEGIN, '0);
        send_op(dq_pkg::KIND_POP, '0);
        send_op(dq_pkg::KIND_CURSOR_READ, '0);
        send_op(KIND_UNUSED_LO, 32'h8000_0000);

        real_ops = 0;
        while (real_ops < RANDOM_OPS) begin
            calm = (real_ops >= RANDOM_OPS - CALM_TAIL);
            if (!calm && ((real_ops / 80) % 3 != 1) && $urandom_range(0, 5) == 0)
                drop_valid($urandom_range(1, 9));
            if (((real_ops / 60) % 4) == 2 && $urandom_range(0, 2) == 0) begin
                // Well-formed cursor walk with random content.
                send_op(dq_pkg::KIND_CURSOR_BEGIN, pick_value());
                real_ops++;
                steps = $urandom_range(1, 8);
                repeat (steps) begin
                    send_op(pick_walk_kind(), pick_value());
                    real_ops++;
                end
            end else begin
                kind = pick_kind((real_ops / 60) % 4);
                send_op(kind, pick_value());
                if (kind < KIND_UNUSED_LO) real_ops++;
            end
        end
        drop_valid(1);

        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
